// File: rtl/ggh_pkg.sv
package ggh_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;
	localparam int GRID       = 3;
	localparam int BINS       = 16;

	localparam int CFG_W     = 13;
	localparam int POS_W     = 12;
	localparam int PIX_W     = 8;
	localparam int COUNT_W   = 21;
	localparam int FRAC_W    = 17;
	localparam int REGION_W  = 4;
	localparam int BIN_W     = 4;
	localparam int REG_IDX_W = 1;

	localparam int GRID_W   = (GRID > 1) ? $clog2(GRID) : 1;
	localparam int BIDX_W   = $clog2(BINS);
	localparam int DEPTH    = GRID * BINS;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int SUBD_W   = $clog2(MAX_WIDTH / GRID + 1);
	localparam int TOTAL_W  = 2 * SUBD_W;
	localparam int Q_W      = FRAC_W;
	localparam int STEP_W   = $clog2(Q_W);

	localparam int RECIP_SH = 17;
	localparam int RECIP    = (2 ** RECIP_SH + GRID - 1) / GRID;
	localparam int RECIP_W  = $clog2(RECIP + 1);

	localparam int RST_WIDTH  = 640;
	localparam int RST_HEIGHT = 480;
	localparam int RST_SUB_W  = RST_WIDTH / GRID;
	localparam int RST_SUB_H  = RST_HEIGHT / GRID;

	localparam logic [FRAC_W-1:0] ONE_Q16 = FRAC_W'(65536);

	typedef enum logic [REG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0]  width;
		logic [CFG_W-1:0]  height;
		logic [SUBD_W-1:0] sub_w;
		logic [SUBD_W-1:0] sub_h;
	} cfg_t;

	typedef struct packed {
		logic accept;
		logic update;
		logic read_bin;
		logic load;
		logic step;
		logic put;
	} cmd_t;

	typedef struct packed {
		logic end_region;
		logic last_bin;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

// File: rtl/grid_gray_histogram_unit.sv
// Channel  Direction  Handshake            Payload
// cfg      in         cfg_write            cfg_index, cfg_data
// pixel    in         in_valid / in_ready  pixel, frame_start
// result   out        out_valid/out_ready  region_index, bin_index, fraction, last, frame_done
//
// A pixel request is handled in the accept cycle and then a read-modify-write of its bin count.
// A pixel that completes a region then emits its 16 bins one after another (read, load, 17 divide steps,
// put) through the bit-serial divider; an output stall holds the put step.
// Reset clears position and all bin counts at once through valid bits and loads a 640 by 480 frame.
// A held output result does not block the next pixel request once the region is emitted.
module grid_gray_histogram_unit
	import ggh_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [PIX_W-1:0]     pixel,
	input  logic                 frame_start,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [REGION_W-1:0]  region_index,
	output logic [BIN_W-1:0]     bin_index,
	output logic [FRAC_W-1:0]    fraction,
	output logic                 last,
	output logic                 frame_done
);

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	ggh_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ggh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ggh_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.sts          (sts),
		.pixel        (pixel),
		.frame_start  (frame_start),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.region_index (region_index),
		.bin_index    (bin_index),
		.fraction     (fraction),
		.last         (last),
		.frame_done   (frame_done)
	);

endmodule

// File: rtl/ggh_cfg.sv
module ggh_cfg
	import ggh_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output cfg_t                 cfg
);

	cfg_t              cfg_q;
	logic [CFG_W-1:0]  width_c;
	logic [CFG_W-1:0]  height_c;

	function automatic logic [CFG_W-1:0] clamp_dim(logic [CFG_W-1:0] v, logic [CFG_W-1:0] hi);
		logic [CFG_W-1:0] r;
		r = v;
		if (v < CFG_W'(GRID)) r = CFG_W'(GRID);
		else if (v > hi) r = hi;
		return r;
	endfunction

	// Division by the grid size as a multiply by a rounded-up reciprocal,
	// which can overshoot by one and is corrected by a single compare.
	function automatic logic [SUBD_W-1:0] sub_dim(logic [CFG_W-1:0] v);
		logic [CFG_W+RECIP_W-1:0] prod;
		logic [CFG_W-1:0]         q;
		logic [CFG_W+GRID_W:0]    back;
		prod = (CFG_W+RECIP_W)'(v) * (CFG_W+RECIP_W)'(RECIP);
		q    = CFG_W'(prod >> RECIP_SH);
		back = (CFG_W+GRID_W+1)'(q) * (CFG_W+GRID_W+1)'(GRID);
		if (back > (CFG_W+GRID_W+1)'(v)) q = q - 1'b1;
		return q[SUBD_W-1:0];
	endfunction

	always_comb begin
		width_c  = clamp_dim(cfg_data, CFG_W'(MAX_WIDTH));
		height_c = clamp_dim(cfg_data, CFG_W'(MAX_HEIGHT));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= CFG_W'(RST_WIDTH);
			cfg_q.height <= CFG_W'(RST_HEIGHT);
			cfg_q.sub_w  <= SUBD_W'(RST_SUB_W);
			cfg_q.sub_h  <= SUBD_W'(RST_SUB_H);
		end else if (cfg_write) begin
			unique case (reg_idx_t'(cfg_index))
				REG_FRAME_WIDTH: begin
					cfg_q.width <= width_c;
					cfg_q.sub_w <= sub_dim(width_c);
				end
				REG_FRAME_HEIGHT: begin
					cfg_q.height <= height_c;
					cfg_q.sub_h  <= sub_dim(height_c);
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/ggh_ctrl.sv
module ggh_ctrl
	import ggh_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_UPDATE,
		S_READ,
		S_LOAD,
		S_DIVIDE,
		S_PUT
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   accept;

	assign accept = in_valid && in_ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			in_ready_q <= 1'b1;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q    <= S_UPDATE;
						in_ready_q <= 1'b0;
					end
				end
				S_UPDATE: begin
					if (sts.end_region) begin
						state_q <= S_READ;
					end else begin
						state_q    <= S_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				S_READ: state_q <= S_LOAD;
				S_LOAD: state_q <= S_DIVIDE;
				S_DIVIDE: begin
					if (sts.div_done) state_q <= S_PUT;
				end
				S_PUT: begin
					if (sts.out_free) begin
						if (sts.last_bin) begin
							state_q    <= S_IDLE;
							in_ready_q <= 1'b1;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				default: begin
					state_q    <= S_IDLE;
					in_ready_q <= 1'b1;
				end
			endcase
		end
	end

	always_comb begin
		cmd.accept   = accept;
		cmd.update   = (state_q == S_UPDATE);
		cmd.read_bin = (state_q == S_READ);
		cmd.load     = (state_q == S_LOAD);
		cmd.step     = (state_q == S_DIVIDE);
		cmd.put      = (state_q == S_PUT) && sts.out_free;
	end

	assign in_ready = in_ready_q;

endmodule

// File: rtl/ggh_dp.sv
module ggh_dp
	import ggh_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  cmd_t                cmd,
	output sts_t                sts,
	input  logic [PIX_W-1:0]    pixel,
	input  logic                frame_start,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [REGION_W-1:0] region_index,
	output logic [BIN_W-1:0]    bin_index,
	output logic [FRAC_W-1:0]   fraction,
	output logic                last,
	output logic                frame_done
);

	logic [POS_W-1:0]   col_q;
	logic [POS_W-1:0]   row_q;
	logic [DEPTH-1:0]   vld_q;
	logic               out_valid_q;
	logic [BIDX_W-1:0]  bin_cnt_q;
	logic [STEP_W-1:0]  step_cnt_q;
	logic               counted_s1;
	logic               end_s1;

	logic [ADDR_W-1:0]  addr_s1;
	logic [GRID_W-1:0]  rc_s1;
	logic [GRID_W-1:0]  band_s1;

	logic [COUNT_W-1:0] mem [DEPTH];
	logic [COUNT_W-1:0] rd_data_q;
	logic [TOTAL_W-1:0] total_q;
	logic               sat_q;
	logic [TOTAL_W-1:0] rem_q;
	logic [Q_W-1:0]     quo_q;

	logic [REGION_W-1:0] region_q;
	logic [BIN_W-1:0]    bin_q;
	logic [FRAC_W-1:0]   frac_q;
	logic                last_q;
	logic                done_q;

	logic [POS_W-1:0]   col;
	logic [POS_W-1:0]   row;
	logic [CFG_W-1:0]   col_bnd [GRID];
	logic [CFG_W-1:0]   row_bnd [GRID];
	logic [GRID_W-1:0]  rc;
	logic [GRID_W-1:0]  band;
	logic               col_end;
	logic               row_end;
	logic               col_in;
	logic               row_in;
	logic [CFG_W-1:0]   col_inc;
	logic [CFG_W-1:0]   row_inc;
	logic [POS_W-1:0]   col_n;
	logic [POS_W-1:0]   row_n;
	logic [BIDX_W-1:0]  pix_bin;
	logic [ADDR_W-1:0]  pix_addr;
	logic [ADDR_W-1:0]  emit_addr;
	logic [ADDR_W-1:0]  rd_addr;
	logic [ADDR_W-1:0]  cur_addr;
	logic [COUNT_W-1:0] cur_count;
	logic [COUNT_W-1:0] cnt_inc;
	logic [TOTAL_W:0]   rem2;
	logic               take;
	logic [Q_W:0]       rnd;
	logic [REGION_W-1:0] region;
	logic               last_bin;

	always_comb begin
		col = frame_start ? '0 : col_q;
		row = frame_start ? '0 : row_q;
		for (int k = 0; k < GRID; k++) begin
			col_bnd[k] = CFG_W'((k + 1) * int'(cfg.sub_w));
			row_bnd[k] = CFG_W'((k + 1) * int'(cfg.sub_h));
		end
		rc      = '0;
		band    = '0;
		col_end = 1'b0;
		row_end = 1'b0;
		col_inc = {1'b0, col} + 1'b1;
		row_inc = {1'b0, row} + 1'b1;
		for (int k = 0; k < GRID - 1; k++) begin
			if ({1'b0, col} >= col_bnd[k]) rc = rc + 1'b1;
			if ({1'b0, row} >= row_bnd[k]) band = band + 1'b1;
		end
		for (int k = 0; k < GRID; k++) begin
			if (col_inc == col_bnd[k]) col_end = 1'b1;
			if (row_inc == row_bnd[k]) row_end = 1'b1;
		end
		col_in = ({1'b0, col} < col_bnd[GRID-1]);
		row_in = ({1'b0, row} < row_bnd[GRID-1]);

		if (col_inc >= cfg.width) begin
			col_n = '0;
			row_n = (row_inc >= cfg.height) ? '0 : row_inc[POS_W-1:0];
		end else begin
			col_n = col_inc[POS_W-1:0];
			row_n = row;
		end

		pix_bin   = BIDX_W'((int'(pixel) * BINS) >> PIX_W);
		pix_addr  = ADDR_W'(int'(rc) * BINS + int'(pix_bin));
		emit_addr = ADDR_W'(int'(rc_s1) * BINS + int'(bin_cnt_q));
		rd_addr   = cmd.accept ? pix_addr : emit_addr;
		cur_addr  = cmd.update ? addr_s1 : emit_addr;
		cur_count = vld_q[cur_addr] ? rd_data_q : '0;
		cnt_inc   = cur_count + 1'b1;

		rem2 = {rem_q, 1'b0};
		take = (rem2 >= {1'b0, total_q});
		rnd  = {1'b0, quo_q} + 1'b1;

		region   = REGION_W'(int'(band_s1) * GRID + int'(rc_s1));
		last_bin = (bin_cnt_q == BIDX_W'(BINS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
			bin_cnt_q   <= '0;
			step_cnt_q  <= '0;
			counted_s1  <= 1'b0;
			end_s1      <= 1'b0;
		end else begin
			if (cmd.accept) begin
				col_q      <= col_n;
				row_q      <= row_n;
				counted_s1 <= col_in && row_in;
				end_s1     <= col_in && row_in && col_end && row_end;
				if (frame_start) vld_q <= '0;
			end
			if (cmd.update && counted_s1) vld_q[addr_s1] <= 1'b1;
			if (cmd.load) step_cnt_q <= '0;
			if (cmd.step) step_cnt_q <= step_cnt_q + 1'b1;
			if (cmd.put) begin
				vld_q[emit_addr] <= 1'b0;
				bin_cnt_q        <= last_bin ? '0 : bin_cnt_q + 1'b1;
				out_valid_q      <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			addr_s1 <= pix_addr;
			rc_s1   <= rc;
			band_s1 <= band;
		end
		if (cmd.update && counted_s1) mem[addr_s1] <= cnt_inc;
		rd_data_q <= mem[rd_addr];
		total_q   <= TOTAL_W'(cfg.sub_w) * TOTAL_W'(cfg.sub_h);
		if (cmd.load) begin
			sat_q <= (TOTAL_W'(cur_count) >= total_q);
			rem_q <= TOTAL_W'(cur_count);
			quo_q <= '0;
		end
		if (cmd.step) begin
			if (take) begin
				rem_q <= TOTAL_W'(rem2 - {1'b0, total_q});
				quo_q <= {quo_q[Q_W-2:0], 1'b1};
			end else begin
				rem_q <= rem2[TOTAL_W-1:0];
				quo_q <= {quo_q[Q_W-2:0], 1'b0};
			end
		end
		if (cmd.put) begin
			region_q <= region;
			bin_q    <= BIN_W'(bin_cnt_q);
			frac_q   <= sat_q ? ONE_Q16 : rnd[Q_W:1];
			last_q   <= last_bin;
			done_q   <= last_bin && (region == REGION_W'(GRID * GRID - 1));
		end
	end

	always_comb begin
		sts.end_region = end_s1;
		sts.last_bin   = last_bin;
		sts.div_done   = (step_cnt_q == STEP_W'(Q_W - 1));
		sts.out_free   = !out_valid_q || out_ready;
	end

	assign out_valid    = out_valid_q;
	assign region_index = region_q;
	assign bin_index    = bin_q;
	assign fraction     = frac_q;
	assign last         = last_q;
	assign frame_done   = done_q;

endmodule

// File: rtl/ggh_checker.sv
module ggh_checker
	import ggh_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [REGION_W-1:0]  region_index,
	input logic [BIN_W-1:0]     bin_index,
	input logic [FRAC_W-1:0]    fraction,
	input logic                 last,
	input logic                 frame_done
);

	// Every pixel request is followed by in_ready going low for its count update.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("pixel request accepted back to back");

	// While a region's bins are still being emitted, no pixel request is taken.
	a_no_input_mid_region: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("pixel request open while a region is emitted");

	a_last_is_final_bin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> bin_index == BIN_W'(BINS - 1))
		else $error("last flag on a bin other than the final one");

	a_frame_done_region: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> last && region_index == REGION_W'(GRID * GRID - 1))
		else $error("frame_done outside the final bin of the last region");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(fraction) && $stable(bin_index))
		else $error("stalled result changed");

endmodule

bind grid_gray_histogram_unit ggh_checker u_ggh_checker (.*);
